// File: rtl/core/two_stage_watchdog_timer_macros.svh
// Assertion macros for the two-stage watchdog timer.
`ifndef TWO_STAGE_WATCHDOG_TIMER_MACROS_SVH
`define TWO_STAGE_WATCHDOG_TIMER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TSWD_ASSERT_IMP(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TSWD_ASSERT_NXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/core/tswd_pkg.sv
// Shared types and constants of the two-stage watchdog timer.
package tswd_pkg;

    // Preload and counter width default
    localparam int unsigned PRELOAD_WIDTH_DEF = 20;

    // Register byte offsets
    localparam logic [3:0] OFF_PRE1   = 4'h0;
    localparam logic [3:0] OFF_PRE2   = 4'h4;
    localparam logic [3:0] OFF_STATUS = 4'h8;
    localparam logic [3:0] OFF_RELOAD = 4'hC;

    // Unlock keys, compared in the low 16 bits
    localparam logic [15:0] KEY_FIRST  = 16'h0080;
    localparam logic [15:0] KEY_SECOND = 16'h0086;

    // Bit positions in written and read data
    localparam int unsigned BIT_RELOAD  = 8;
    localparam int unsigned BIT_TIMEOUT = 9;
    localparam int unsigned BIT_MODE    = 2;
    localparam int unsigned BIT_ENABLE  = 1;
    localparam int unsigned BIT_LOCK    = 0;
    localparam int unsigned BIT_PRETO   = 0;

    // Item kinds
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_LOCK  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req_type;

    // Unlock sequence phase
    typedef enum logic [1:0] {
        PH_LOCKED = 2'd0,
        PH_KEY1   = 2'd1,
        PH_OPEN   = 2'd2
    } t_unlock;

    // Control status seen by the top level
    typedef struct packed {
        logic enable;
        logic wd_mode;
        logic lock;
        logic in_second;
    } t_tswd_status;

endpackage

// File: rtl/core/tswd_core.sv
// Watchdog register file, unlock sequence and two-stage down counter.
module tswd_core
    import tswd_pkg::*;
#(
    parameter int unsigned PRELOAD_WIDTH = PRELOAD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_req_type    i_req_type,
    input  logic [3:0]   i_reg_offset,
    input  logic [31:0]  i_write_data,
    output logic [31:0]  o_read_data,
    output logic         o_reset_pulse,
    output logic         o_write_ignored,
    output logic         o_armed,
    output t_tswd_status o_status
);

    t_unlock                  r_phase, n_phase;
    logic [PRELOAD_WIDTH-1:0] r_pre1, n_pre1;
    logic [PRELOAD_WIDTH-1:0] r_pre2, n_pre2;
    logic [PRELOAD_WIDTH-1:0] r_cnt, n_cnt;
    logic                     r_second, n_second;
    logic                     r_timeout, n_timeout;
    logic                     r_preto, n_preto;
    logic                     r_enable, n_enable;
    logic                     r_mode, n_mode;
    logic                     r_lock, n_lock;

    logic is_write;
    logic is_key1;
    logic is_key2;
    logic mapped;
    logic open_ph;

    // Decode of the request kind, the unlock keys and the mapped offsets
    assign is_write = (i_req_type == REQ_WRITE);
    assign is_key1  = (i_reg_offset == OFF_RELOAD) && (i_write_data[15:0] == KEY_FIRST);
    assign is_key2  = (i_reg_offset == OFF_RELOAD) && (i_write_data[15:0] == KEY_SECOND)
                      && (r_phase == PH_KEY1);
    assign mapped   = (i_reg_offset == OFF_PRE1) || (i_reg_offset == OFF_PRE2)
                      || (i_reg_offset == OFF_STATUS) || (i_reg_offset == OFF_RELOAD);
    assign open_ph  = (r_phase == PH_OPEN);

    // Unlock phase next state
    always_comb begin
        n_phase = r_phase;
        if (is_write) begin
            if (is_key1) begin
                n_phase = PH_KEY1;
            end else if (is_key2) begin
                n_phase = PH_OPEN;
            end else if (mapped) begin
                n_phase = PH_LOCKED;
            end
        end
    end

    // Register, lock and counter update plus the result fields
    always_comb begin
        n_pre1          = r_pre1;
        n_pre2          = r_pre2;
        n_cnt           = r_cnt;
        n_second        = r_second;
        n_timeout       = r_timeout;
        n_preto         = r_preto;
        n_enable        = r_enable;
        n_mode          = r_mode;
        n_lock          = r_lock;
        o_read_data     = '0;
        o_reset_pulse   = 1'b0;
        o_write_ignored = 1'b0;
        case (i_req_type)
            REQ_WRITE: begin
                if (!is_key1 && !is_key2) begin
                    case (i_reg_offset)
                        OFF_PRE1: begin
                            if (open_ph) n_pre1 = i_write_data[PRELOAD_WIDTH-1:0];
                            else o_write_ignored = 1'b1;
                        end
                        OFF_PRE2: begin
                            if (open_ph) n_pre2 = i_write_data[PRELOAD_WIDTH-1:0];
                            else o_write_ignored = 1'b1;
                        end
                        OFF_STATUS: begin
                            // write one to clear
                            if (i_write_data[BIT_PRETO]) n_preto = 1'b0;
                        end
                        OFF_RELOAD: begin
                            if (open_ph) begin
                                if (i_write_data[BIT_RELOAD]) begin
                                    n_cnt    = r_pre1;
                                    n_second = 1'b0;
                                end
                                if (i_write_data[BIT_TIMEOUT]) n_timeout = 1'b0;
                            end else begin
                                o_write_ignored = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            REQ_READ: begin
                case (i_reg_offset)
                    OFF_PRE1:   o_read_data = 32'(r_pre1);
                    OFF_PRE2:   o_read_data = 32'(r_pre2);
                    OFF_STATUS: o_read_data[BIT_PRETO] = r_preto;
                    OFF_RELOAD: o_read_data[BIT_TIMEOUT] = r_timeout;
                    default:    o_read_data = '0;
                endcase
            end
            REQ_LOCK: begin
                if (r_lock) begin
                    o_write_ignored = 1'b1;
                end else begin
                    n_enable = i_write_data[BIT_ENABLE];
                    n_mode   = i_write_data[BIT_MODE];
                    n_lock   = i_write_data[BIT_LOCK];
                    // rising enable restarts stage one
                    if (i_write_data[BIT_ENABLE] && !r_enable) begin
                        n_cnt    = r_pre1;
                        n_second = 1'b0;
                    end
                end
            end
            REQ_TICK: begin
                if (r_enable) begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end else if (!r_second) begin
                        // stage one expired: arm stage two
                        n_second = 1'b1;
                        n_cnt    = r_pre2;
                        n_preto  = 1'b1;
                    end else begin
                        // stage two expired
                        if (r_mode) begin
                            o_reset_pulse = 1'b1;
                            n_timeout     = 1'b1;
                        end
                        n_cnt    = r_pre1;
                        n_second = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        o_armed = n_enable;
    end

    // State registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LOCKED;
            r_pre1    <= '0;
            r_pre2    <= '0;
            r_cnt     <= '0;
            r_second  <= 1'b0;
            r_timeout <= 1'b0;
            r_preto   <= 1'b0;
            r_enable  <= 1'b0;
            r_mode    <= 1'b0;
            r_lock    <= 1'b0;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_pre1    <= n_pre1;
            r_pre2    <= n_pre2;
            r_cnt     <= n_cnt;
            r_second  <= n_second;
            r_timeout <= n_timeout;
            r_preto   <= n_preto;
            r_enable  <= n_enable;
            r_mode    <= n_mode;
            r_lock    <= n_lock;
        end
    end

    assign o_status = '{enable: r_enable, wd_mode: r_mode, lock: r_lock, in_second: r_second};

endmodule

// File: rtl/core/two_stage_watchdog_timer.sv
// Two-stage watchdog timer top level: stream ports, input and result registers.
// Each item (register write, register read, lock write or prescaled tick) gives
// exactly one result. The block takes one item per clock while the receiver keeps
// up. A result passes through the input register, one pass through the register
// and counter logic, and the result register before it is offered. While the
// receiver holds off, the two registers keep one item each and then tready drops.
// Protected writes need the keys 0x80 then 0x86 written to the reload register
// first. PRELOAD_WIDTH (8 to 32) sets the width of the preloads and the down
// counter.
`include "two_stage_watchdog_timer_macros.svh"

module two_stage_watchdog_timer
    import tswd_pkg::*;
#(
    parameter int unsigned PRELOAD_WIDTH = PRELOAD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [3:0] reg_offset, [35:4] write_data, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [31:0] read_data, [32] reset_pulse,
                                     // [33] write_ignored, [34] armed, rest zero
);

    logic         r_in_valid;
    t_req_type    r_in_req;
    logic [3:0]   r_in_off;
    logic [31:0]  r_in_data;
    logic         r_out_valid;
    logic [31:0]  r_out_rd;
    logic         r_out_pulse;
    logic         r_out_ign;
    logic         r_out_armed;

    logic         adv;
    logic         proc;
    logic [31:0]  rd;
    logic         pulse;
    logic         ign;
    logic         armed;
    t_tswd_status st;

    // Pipeline moves when the result register is free or being taken
    assign adv        = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req  <= t_req_type'(i_s_tuser);
            r_in_off  <= i_s_tdata[3:0];
            r_in_data <= i_s_tdata[35:4];
        end
    end

    tswd_core #(
        .PRELOAD_WIDTH (PRELOAD_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (proc),
        .i_req_type      (r_in_req),
        .i_reg_offset    (r_in_off),
        .i_write_data    (r_in_data),
        .o_read_data     (rd),
        .o_reset_pulse   (pulse),
        .o_write_ignored (ign),
        .o_armed         (armed),
        .o_status        (st)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_rd    <= rd;
            r_out_pulse <= pulse;
            r_out_ign   <= ign;
            r_out_armed <= armed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_armed, r_out_ign, r_out_pulse, r_out_rd};

    // A reset pulse comes only from watchdog mode and leaves stage one selected
    `TSWD_ASSERT_IMP(a_pulse_mode, r_out_valid && r_out_pulse, st.wd_mode && !st.in_second, "reset pulse outside watchdog mode")
    // The result's armed flag matches the enable state after its item
    `TSWD_ASSERT_IMP(a_armed_match, r_out_valid, r_out_armed == st.enable, "armed flag out of step with enable")
    // The lock bit holds until reset
    `TSWD_ASSERT_NXT(a_lock_sticky, st.lock, st.lock, "lock bit cleared without reset")

endmodule

// File: tb/two_stage_watchdog_timer_test.sv
// Self-checking testbench for the two-stage watchdog timer: directed and random items.
import tswd_pkg::*;

// Result fields, packed as on the master data bus from bit 0 up
typedef struct packed {
    logic        armed;
    logic        ignored;
    logic        pulse;
    logic [31:0] rdata;
} t_wdt_result;

// Shadow copy of the watchdog registers; predicts and checks one result per item
class wdt_shadow;
    t_unlock                      phase;
    logic [PRELOAD_WIDTH_DEF-1:0] pre1;
    logic [PRELOAD_WIDTH_DEF-1:0] pre2;
    logic [PRELOAD_WIDTH_DEF-1:0] count;
    bit                           second_stage;
    bit                           timeout_seen;
    bit                           preto;
    bit                           en;
    bit                           wd_mode;
    bit                           locked;
    t_wdt_result                  expected_results[$];
    int                           failures;
    int                           checked;
    int                           pulses_seen;
    int                           drops_seen;

    function new();
        phase        = PH_LOCKED;
        pre1         = '0;
        pre2         = '0;
        count        = '0;
        second_stage = 0;
        timeout_seen = 0;
        preto        = 0;
        en           = 0;
        wd_mode      = 0;
        locked       = 0;
        failures     = 0;
        checked      = 0;
        pulses_seen  = 0;
        drops_seen   = 0;
    endfunction

    function void restart_stage_one();
        count        = pre1;
        second_stage = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Apply one accepted item to the shadow state and queue its result
    function void note_item(t_req_type kind, logic [3:0] off, logic [31:0] data);
        t_wdt_result r;
        bit          was_en;
        r = '0;
        case (kind)
            REQ_WRITE: begin
                if (off == OFF_RELOAD && data[15:0] == KEY_FIRST) begin
                    phase = PH_KEY1;
                end else if (off == OFF_RELOAD && data[15:0] == KEY_SECOND
                             && phase == PH_KEY1) begin
                    phase = PH_OPEN;
                end else begin
                    case (off)
                        OFF_PRE1: begin
                            if (phase == PH_OPEN) pre1 = data[PRELOAD_WIDTH_DEF-1:0];
                            else r.ignored = 1'b1;
                        end
                        OFF_PRE2: begin
                            if (phase == PH_OPEN) pre2 = data[PRELOAD_WIDTH_DEF-1:0];
                            else r.ignored = 1'b1;
                        end
                        OFF_STATUS: begin
                            // write one to clear
                            if (data[BIT_PRETO]) preto = 0;
                        end
                        OFF_RELOAD: begin
                            if (phase == PH_OPEN) begin
                                if (data[BIT_RELOAD]) restart_stage_one();
                                if (data[BIT_TIMEOUT]) timeout_seen = 0;
                            end else begin
                                r.ignored = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    // any mapped write consumes the unlock; unmapped ones leave it
                    if (off == OFF_PRE1 || off == OFF_PRE2 || off == OFF_STATUS ||
                        off == OFF_RELOAD)
                        phase = PH_LOCKED;
                end
            end
            REQ_READ: begin
                case (off)
                    OFF_PRE1:   r.rdata = 32'(pre1);
                    OFF_PRE2:   r.rdata = 32'(pre2);
                    OFF_STATUS: r.rdata[BIT_PRETO] = preto;
                    OFF_RELOAD: r.rdata[BIT_TIMEOUT] = timeout_seen;
                    default:    r.rdata = '0;
                endcase
            end
            REQ_LOCK: begin
                if (locked) begin
                    r.ignored = 1'b1;
                end else begin
                    was_en  = en;
                    en      = data[BIT_ENABLE];
                    wd_mode = data[BIT_MODE];
                    locked  = data[BIT_LOCK];
                    if (en && !was_en) restart_stage_one();
                end
            end
            default: begin
                // prescaled tick
                if (en) begin
                    if (count != 0) begin
                        count = count - 1'b1;
                    end else if (!second_stage) begin
                        second_stage = 1;
                        count        = pre2;
                        preto        = 1;
                    end else begin
                        if (wd_mode) begin
                            r.pulse      = 1'b1;
                            timeout_seen = 1;
                        end
                        restart_stage_one();
                    end
                end
            end
        endcase
        r.armed = en;
        expected_results.push_back(r);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        failures++;
        if (failures <= 50)
            $display("result %0d: %s is %h, expected %h", checked, field, got, want);
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(logic [39:0] tdata);
        t_wdt_result want;
        checked++;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", tdata[31:0], '0);
        end else begin
            want = expected_results.pop_front();
            if (tdata[31:0] !== want.rdata)
                report_mismatch("read_data", tdata[31:0], want.rdata);
            if (tdata[32] !== want.pulse)
                report_mismatch("reset_pulse", 32'(tdata[32]), 32'(want.pulse));
            if (tdata[33] !== want.ignored)
                report_mismatch("write_ignored", 32'(tdata[33]), 32'(want.ignored));
            if (tdata[34] !== want.armed)
                report_mismatch("armed", 32'(tdata[34]), 32'(want.armed));
            if (want.pulse) pulses_seen++;
            if (want.ignored) drops_seen++;
        end
    endtask
endclass

module two_stage_watchdog_timer_test;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_END   = 1510;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // [3:0] reg_offset, [35:4] write_data, rest zero
    logic [1:0]  i_s_tuser  = '0;   // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // [31:0] read_data, [32] reset_pulse,
                                    // [33] write_ignored, [34] armed, rest zero

    int send_idle_pct = 13;
    int recv_idle_pct = 86;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int idle_cycles   = 0;
    bit lock_allowed  = 0;
    wdt_shadow sb;

    two_stage_watchdog_timer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_m_tready  <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("two_stage_watchdog_timer regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, idling cycle by cycle first, and wait for it to be taken
    task send_item(t_req_type kind, logic [3:0] off, logic [31:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'b0, data, off};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_item(kind, off, data);
        items_sent++;
    endtask

    // Key pair on the reload register, random upper halves
    task unlock();
        logic [15:0] hi;
        hi = 16'($urandom);
        send_item(REQ_WRITE, OFF_RELOAD, {hi, KEY_FIRST});
        hi = 16'($urandom);
        send_item(REQ_WRITE, OFF_RELOAD, {hi, KEY_SECOND});
    endtask

    // Hold the sender until every predicted result has come back
    task drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly short preloads so that both stages expire; sometimes full random
    function logic [31:0] preload_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 8);
    endfunction

    // One random sequence: mostly well-formed, some broken or noise
    task random_sequence();
        int          sel;
        int          n;
        logic [3:0]  off;
        logic [31:0] data;
        logic [15:0] hi;
        sel  = $urandom_range(0, 99);
        data = $urandom;
        off  = 4'($urandom);
        if ($urandom_range(0, 4) != 0) off = 4'($urandom_range(0, 3) * 4);
        if (sel < 30) begin
            n = $urandom_range(1, 12);
            repeat (n) send_item(REQ_TICK, 4'($urandom), $urandom);
        end else if (sel < 50) begin
            unlock();
            case ($urandom_range(0, 2))
                0:       send_item(REQ_WRITE, OFF_PRE1, preload_value());
                1:       send_item(REQ_WRITE, OFF_PRE2, preload_value());
                default: send_item(REQ_WRITE, OFF_RELOAD, data);
            endcase
        end else if (sel < 65) begin
            send_item(REQ_READ, off, data);
        end else if (sel < 75) begin
            if (!lock_allowed) data[BIT_LOCK] = 1'b0;
            data[BIT_ENABLE] = ($urandom_range(0, 4) != 0);
            send_item(REQ_LOCK, off, data);
        end else if (sel < 83) begin
            send_item(REQ_WRITE, OFF_STATUS, data);
        end else if (sel < 90) begin
            hi = 16'($urandom);
            case ($urandom_range(0, 2))
                0: begin
                    // first key, then something other than the second key
                    send_item(REQ_WRITE, OFF_RELOAD, {hi, KEY_FIRST});
                    send_item(REQ_WRITE, off, data);
                end
                1: begin
                    // second key alone does not unlock
                    send_item(REQ_WRITE, OFF_RELOAD, {hi, KEY_SECOND});
                    send_item(REQ_WRITE, OFF_PRE1, preload_value());
                end
                default: begin
                    // unmapped write between the keys keeps the phase
                    send_item(REQ_WRITE, OFF_RELOAD, {hi, KEY_FIRST});
                    send_item(REQ_WRITE, 4'(3 + 4 * $urandom_range(0, 3)), data);
                    send_item(REQ_WRITE, OFF_RELOAD, {hi, KEY_SECOND});
                    send_item(REQ_WRITE, OFF_PRE2, preload_value());
                end
            endcase
        end else begin
            off = 4'($urandom);
            sel = $urandom_range(0, 3);
            if (t_req_type'(sel) == REQ_LOCK && !lock_allowed) data[BIT_LOCK] = 1'b0;
            send_item(t_req_type'(sel), off, data);
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, protection, key handling, both expiries
        send_item(REQ_READ, OFF_PRE1, 32'h0);
        send_item(REQ_TICK, OFF_PRE1, 32'h0);
        send_item(REQ_WRITE, OFF_PRE1, 32'h5);
        send_item(REQ_WRITE, OFF_RELOAD, 32'hFFFF_0080);
        send_item(REQ_WRITE, OFF_RELOAD, 32'h0000_0086);
        send_item(REQ_WRITE, OFF_PRE1, 32'hFFFF_FFFF);
        send_item(REQ_READ, OFF_PRE1, 32'hFFFF_FFFF);
        unlock();
        send_item(REQ_WRITE, OFF_PRE1, 32'h1);
        unlock();
        send_item(REQ_WRITE, OFF_PRE2, 32'h0);
        send_item(REQ_LOCK, 4'h0, 32'h6);
        repeat (3) send_item(REQ_TICK, 4'hF, 32'h0);
        send_item(REQ_READ, OFF_STATUS, 32'h0);
        send_item(REQ_READ, OFF_RELOAD, 32'h0);
        send_item(REQ_WRITE, OFF_STATUS, 32'h1);
        send_item(REQ_WRITE, 4'hF, 32'hFFFF_FFFF);
        send_item(REQ_READ, 4'hF, 32'h0);
        unlock();
        send_item(REQ_WRITE, OFF_RELOAD, 32'h0000_0300);

        // Random: three idling phases, drained between them
        while (items_sent < RANDOM_END) begin
            if (items_sent >= 525 && send_idle_pct == 13) begin
                drain();
                send_idle_pct = 86;
                recv_idle_pct = 13;
            end else if (items_sent >= 1050 && send_idle_pct == 86) begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests <= hold_requests + 1;
            end else if (items_sent == 200) begin
                hold_requests <= hold_requests + 1;
            end
            random_sequence();
        end

        // Set the sticky lock bit, then check that lock writes are dropped
        drain();
        lock_allowed = 1;
        send_item(REQ_LOCK, 4'h0, 32'h7);
        send_item(REQ_LOCK, 4'h0, 32'h0);
        repeat (12) random_sequence();

        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items, %0d results checked; %0d reset pulses, %0d dropped writes",
                 items_sent, sb.checked, sb.pulses_seen, sb.drops_seen);
        if (sb.failures == 0)
            $display("two_stage_watchdog_timer regression: pass");
        else
            $display("two_stage_watchdog_timer regression: fail");
        $finish;
    end
endmodule

// File: two_stage_watchdog_timer.f
+incdir+rtl/core
rtl/core/tswd_pkg.sv
rtl/core/tswd_core.sv
rtl/core/two_stage_watchdog_timer.sv
tb/two_stage_watchdog_timer_test.sv
